[src/tsv_pkg.sv]
// Shared types and constants for the text source validator.
`timescale 1ns / 1ps
package tsv_pkg;

  localparam int CNT_W    = 25;
  localparam int TEXT_W   = 25;
  localparam int MAX_W    = 24;
  localparam int RATIO_W  = 8;
  localparam int PROD_W   = CNT_W + RATIO_W;
  localparam int WIDE_W   = ((CNT_W > MAX_W) ? CNT_W : MAX_W) + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [TEXT_W-1:0] TEXT_MAX = {TEXT_W{1'b1}};

  localparam logic [MAX_W-1:0]   MAX_SRC_RESET = MAX_W'(4194304);
  localparam logic [RATIO_W-1:0] RATIO_RESET   = RATIO_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SRC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = CFG_IDX_W'(1);

  // Minimum code point class of an open UTF-8 sequence.
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_2B   = 2'd1;
  localparam logic [1:0] CLS_3B   = 2'd2;
  localparam logic [1:0] CLS_4B   = 2'd3;

  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_2B    = 21'h000080;
  localparam logic [20:0] CP_MIN_3B    = 21'h000800;
  localparam logic [20:0] CP_MIN_4B    = 21'h010000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_BAD_BOM   = 3'd2,
    ST_BINARY    = 3'd3,
    ST_BAD_UTF8  = 3'd4
  } status_t;

  // Summary of one finished source, handed from the scanner to the verdict logic.
  typedef struct packed {
    logic [CNT_W-1:0] raw_count;
    logic [CNT_W-1:0] text_count;
    logic [CNT_W-1:0] ctrl_count;
    logic             zero_seen;
    logic             bom8;
    logic             bad_bom;
    logic             utf_bad;
  } rpt_t;

endpackage

[src/tsv_scan.sv]
// Per-byte scanner: counters, head bytes, UTF-8 decoder and end-of-source summary.
`timescale 1ns / 1ps
module tsv_scan import tsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       last,
  output rpt_t       rpt
);

  logic [CNT_W-1:0] raw_r, raw_nxt;
  logic [CNT_W-1:0] ctrl_r, ctrl_nxt;
  logic [31:0]      head_r, head_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [20:0]      part_r, part_nxt;
  logic [1:0]       cls_r, cls_nxt;
  logic             zero_r, zero_nxt;
  logic             err_r, err_nxt;
  logic [20:0]      cp_min;
  logic             is_ctrl;

  assign is_ctrl = ((data_byte < 8'h20) || (data_byte == 8'h7F)) &&
                   (data_byte != 8'h09) && (data_byte != 8'h0A) && (data_byte != 8'h0D);

  always_comb begin
    case (cls_r)
      CLS_2B:  cp_min = CP_MIN_2B;
      CLS_3B:  cp_min = CP_MIN_3B;
      default: cp_min = CP_MIN_4B;
    endcase
  end

  always_comb begin
    raw_nxt  = raw_r;
    ctrl_nxt = ctrl_r;
    head_nxt = head_r;
    pend_nxt = pend_r;
    part_nxt = part_r;
    cls_nxt  = cls_r;
    zero_nxt = zero_r;
    err_nxt  = err_r;
    if (has_byte) begin
      if (raw_r < CNT_W'(4)) begin
        head_nxt[8*raw_r[1:0] +: 8] = data_byte;
      end
      if (raw_r != CNT_MAX) begin
        raw_nxt = raw_r + 1'b1;
      end
      if (data_byte == 8'h00) begin
        zero_nxt = 1'b1;
      end else if (is_ctrl && (ctrl_r != CNT_MAX)) begin
        ctrl_nxt = ctrl_r + 1'b1;
      end
      // The decoder freezes after its first error.
      if (!err_r) begin
        if (pend_r == 2'd0) begin
          if (data_byte <= 8'h7F) begin
            err_nxt = 1'b0;
          end else if ((data_byte >= 8'hC2) && (data_byte <= 8'hDF)) begin
            pend_nxt = 2'd1;
            part_nxt = 21'(data_byte[4:0]);
            cls_nxt  = CLS_2B;
          end else if ((data_byte >= 8'hE0) && (data_byte <= 8'hEF)) begin
            pend_nxt = 2'd2;
            part_nxt = 21'(data_byte[3:0]);
            cls_nxt  = CLS_3B;
          end else if ((data_byte >= 8'hF0) && (data_byte <= 8'hF4)) begin
            pend_nxt = 2'd3;
            part_nxt = 21'(data_byte[2:0]);
            cls_nxt  = CLS_4B;
          end else begin
            err_nxt = 1'b1;
          end
        end else if (data_byte[7:6] != 2'b10) begin
          err_nxt = 1'b1;
        end else begin
          part_nxt = {part_r[14:0], data_byte[5:0]};
          pend_nxt = pend_r - 2'd1;
          if ((pend_r == 2'd1) &&
              ((part_nxt < cp_min) || (part_nxt > CP_MAX) ||
               ((part_nxt >= CP_SURR_LO) && (part_nxt <= CP_SURR_HI)))) begin
            err_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Summary as it stands once this item's byte is counted.
  always_comb begin
    rpt.raw_count  = raw_nxt;
    rpt.ctrl_count = ctrl_nxt;
    rpt.zero_seen  = zero_nxt;
    rpt.bom8       = (raw_nxt >= CNT_W'(3)) && (head_nxt[7:0] == 8'hEF) &&
                     (head_nxt[15:8] == 8'hBB) && (head_nxt[23:16] == 8'hBF);
    rpt.bad_bom    = ((raw_nxt >= CNT_W'(2)) &&
                      (((head_nxt[7:0] == 8'hFE) && (head_nxt[15:8] == 8'hFF)) ||
                       ((head_nxt[7:0] == 8'hFF) && (head_nxt[15:8] == 8'hFE)))) ||
                     ((raw_nxt >= CNT_W'(4)) && (head_nxt[15:0] == 16'h0000) &&
                      (head_nxt[23:16] == 8'hFE) && (head_nxt[31:24] == 8'hFF));
    rpt.text_count = rpt.bom8 ? (raw_nxt - CNT_W'(3)) : raw_nxt;
    rpt.utf_bad    = err_nxt || (pend_nxt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && last)) begin
      raw_r  <= '0;
      ctrl_r <= '0;
      head_r <= '0;
      pend_r <= '0;
      part_r <= '0;
      cls_r  <= CLS_NONE;
      zero_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (go) begin
      raw_r  <= raw_nxt;
      ctrl_r <= ctrl_nxt;
      head_r <= head_nxt;
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      cls_r  <= cls_nxt;
      zero_r <= zero_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

[src/tsv_verdict.sv]
// Verdict logic: size limit, binary test (zero byte or control ratio) and status priority.
`timescale 1ns / 1ps
module tsv_verdict import tsv_pkg::*; (
  input  rpt_t               rpt,
  input  logic [MAX_W-1:0]   max_source_bytes,
  input  logic [RATIO_W-1:0] control_ratio,
  output status_t            status,
  output logic               bom_stripped,
  output logic [TEXT_W-1:0]  text_bytes
);

  logic [PROD_W-1:0] ctrl_weight;
  logic [WIDE_W-1:0] text_wide;
  logic              too_large;
  logic              binary;

  assign ctrl_weight = PROD_W'(rpt.ctrl_count) * PROD_W'(control_ratio);
  assign text_wide   = WIDE_W'(rpt.text_count);
  assign too_large   = WIDE_W'(rpt.raw_count) > WIDE_W'(max_source_bytes);
  assign binary      = (rpt.text_count != '0) &&
                       (rpt.zero_seen || (ctrl_weight > PROD_W'(rpt.text_count)));

  always_comb begin
    if (too_large) begin
      status = ST_TOO_LARGE;
    end else if (rpt.bad_bom) begin
      status = ST_BAD_BOM;
    end else if (binary) begin
      status = ST_BINARY;
    end else if (rpt.utf_bad) begin
      status = ST_BAD_UTF8;
    end else begin
      status = ST_OK;
    end
  end

  assign bom_stripped = rpt.bom8;
  assign text_bytes   = (text_wide > WIDE_W'(TEXT_MAX)) ? TEXT_MAX : text_wide[TEXT_W-1:0];

endmodule

[src/text_source_validator_top.sv]
// Top level of the text source validator: handshakes, pipeline registers, configuration.
// A result moves through the input, summary and output registers, in that order.
// Throughput: one item per cycle; only a last item stalls, and only while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline, clears the scanner state and loads
// max_source_bytes with 4194304 and control_ratio with 10.
`timescale 1ns / 1ps
module text_source_validator_top import tsv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_has_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic                 out_bom_stripped,
  output logic [TEXT_W-1:0]    out_text_bytes,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAX_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [MAX_W-1:0]   max_src_r;
  logic [RATIO_W-1:0] ratio_r;

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_has_r;
  logic       in_last_r;

  // Summary register between the scanner and the verdict logic.
  logic rpt_vld_r;
  rpt_t rpt_r;
  rpt_t rpt_nxt;

  // Output register.
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic              out_bom_r;
  logic [TEXT_W-1:0] out_text_r;

  status_t           vd_status;
  logic              vd_bom;
  logic [TEXT_W-1:0] vd_text;

  logic out_free;
  logic rpt_free;
  logic in_go;
  logic in_free;

  // Each stage moves when the stage after it is empty or moving. An item that is
  // not last only updates the scanner, so it never waits on the result side.
  assign out_free = !out_valid_r || !out_stall;
  assign rpt_free = !rpt_vld_r || out_free;
  assign in_go    = in_vld_r && (!in_last_r || rpt_free);
  assign in_free  = !in_vld_r || in_go;
  assign in_stall = !in_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_src_r <= MAX_SRC_RESET;
      ratio_r   <= RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SRC: max_src_r <= cfg_data;
        CFG_RATIO:   ratio_r   <= cfg_data[RATIO_W-1:0];
        default:     max_src_r <= max_src_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_free) begin
      in_vld_r <= in_valid;
    end
    if (in_free && in_valid) begin
      in_byte_r <= in_data_byte;
      in_has_r  <= in_has_byte;
      in_last_r <= in_last;
    end
  end

  tsv_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (in_go),
    .data_byte (in_byte_r),
    .has_byte  (in_has_r),
    .last      (in_last_r),
    .rpt       (rpt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_vld_r <= 1'b0;
    end else if (rpt_free) begin
      rpt_vld_r <= in_go && in_last_r;
    end
    if (in_go && in_last_r) begin
      rpt_r <= rpt_nxt;
    end
  end

  tsv_verdict u_verdict (
    .rpt              (rpt_r),
    .max_source_bytes (max_src_r),
    .control_ratio    (ratio_r),
    .status           (vd_status),
    .bom_stripped     (vd_bom),
    .text_bytes       (vd_text)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= rpt_vld_r;
    end
    if (rpt_vld_r && out_free) begin
      out_status_r <= vd_status;
      out_bom_r    <= vd_bom;
      out_text_r   <= vd_text;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_bom_stripped = out_bom_r;
  assign out_text_bytes   = out_text_r;

`ifndef SYNTHESIS
  // A result can only appear when a summary was waiting in the stage before it.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(rpt_vld_r))
    else $error("result appeared without a pending summary");

  // The input side only stalls when the input register holds an item that cannot move.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && in_last_r && rpt_vld_r && !out_free))
    else $error("input stalled without a blocked last item");

  // A summary that cannot move on is held unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (rpt_vld_r && !out_free) |=> (rpt_vld_r && $stable(rpt_r)))
    else $error("blocked summary was lost or changed");
`endif

endmodule
